[sv/tlbimg_pkg.sv]
// shared types and constants for the tlb identity map generator
`timescale 1ns / 1ps

package tlbimg_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned ATTR_W       = 3;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned MASK_W       = 29;
  localparam int unsigned LO_W         = 30;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned STEPS_W      = 4;
  localparam int unsigned ENTRIES_W    = 7;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 7;
  localparam int unsigned PAGE_SHIFT   = 12;
  localparam int unsigned MAX_STEPS    = 8;
  localparam int unsigned NUM_SIZES    = MAX_STEPS + 1;
  localparam int unsigned SEL_W        = 4;
  localparam int unsigned PAGES_W      = 2 * MAX_STEPS;

  localparam logic [STATUS_W-1:0] STAT_ENTRY = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGE_STEPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENTRIES    = 1'b1;

  localparam logic [STEPS_W-1:0]   MAX_STEPS_RESET   = 4'd8;
  localparam logic [ENTRIES_W-1:0] TLB_ENTRIES_RESET = 7'd64;

  typedef enum logic [0:0] {
    CTRL_IDLE,
    CTRL_GEN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic res_last;
  } dp_status_t;

endpackage

[sv/tlbimg_if.sv]
// request channels for regions in and tlb entries out
`timescale 1ns / 1ps

interface tlbimg_region_if;
  import tlbimg_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   start_address;
  logic [LEN_W-1:0]    region_length;
  logic [ATTR_W-1:0]   cache_attr;

  modport source (output valid, output start_address, output region_length,
                  output cache_attr, input ready);
  modport sink   (input valid, input start_address, input region_length,
                  input cache_attr, output ready);
endinterface

interface tlbimg_entry_if;
  import tlbimg_pkg::*;

  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  tlb_index;
  logic [MASK_W-1:0]   page_mask;
  logic [ADDR_W-1:0]   entry_hi;
  logic [LO_W-1:0]     entry_lo_even;
  logic [LO_W-1:0]     entry_lo_odd;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output tlb_index, output page_mask, output entry_hi,
                  output entry_lo_even, output entry_lo_odd, output status,
                  output last, input ready);
  modport sink   (input valid, input tlb_index, input page_mask, input entry_hi,
                  input entry_lo_even, input entry_lo_odd, input status,
                  input last, output ready);
endinterface

[sv/tlbimg_datapath.sv]
// region walker, page size selection, wired counter and result register
`timescale 1ns / 1ps

module tlbimg_datapath #(
  parameter int unsigned WIRED_LIMIT = 63
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tlbimg_pkg::dp_cmd_t              cmd_i,
  output tlbimg_pkg::dp_status_t           status_o,
  input  logic [tlbimg_pkg::ADDR_W-1:0]    start_address_i,
  input  logic [tlbimg_pkg::LEN_W-1:0]     region_length_i,
  input  logic [tlbimg_pkg::ATTR_W-1:0]    cache_attr_i,
  input  logic                             cfg_we_i,
  input  logic [tlbimg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tlbimg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [tlbimg_pkg::INDEX_W-1:0]   tlb_index_o,
  output logic [tlbimg_pkg::MASK_W-1:0]    page_mask_o,
  output logic [tlbimg_pkg::ADDR_W-1:0]    entry_hi_o,
  output logic [tlbimg_pkg::LO_W-1:0]      entry_lo_even_o,
  output logic [tlbimg_pkg::LO_W-1:0]      entry_lo_odd_o,
  output logic [tlbimg_pkg::STATUS_W-1:0]  entry_status_o,
  output logic                             last_o
);
  import tlbimg_pkg::*;

  localparam logic [INDEX_W-1:0] LIMIT = INDEX_W'(WIRED_LIMIT);

  logic [ADDR_W-1:0]    start_q, start_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [ATTR_W-1:0]    attr_q;
  logic [INDEX_W-1:0]   wired_q, wired_d;
  logic [STEPS_W-1:0]   steps_cfg_q;
  logic [ENTRIES_W-1:0] entries_cfg_q;

  logic [INDEX_W-1:0]   idx_q;
  logic [MASK_W-1:0]    mask_q;
  logic [ADDR_W-1:0]    hi_q;
  logic [LO_W-1:0]      lo_even_q, lo_odd_q;
  logic [STATUS_W-1:0]  stat_q;
  logic                 last_q;

  logic [STEPS_W-1:0]   steps;
  logic [NUM_SIZES-1:0] size_ok;
  logic [SEL_W-1:0]     sel;
  logic [ADDR_W-1:0]    sz, two_sz, advance, odd_addr;
  logic                 odd, len_zero, full, short_len;
  logic [PAGES_W-1:0]   pages_m1;
  logic [LEN_W-1:0]     len_next;

  function automatic logic [LO_W-1:0] lo_word(input logic [ADDR_W-1:0] addr,
                                              input logic [ATTR_W-1:0] attr);
    lo_word = {4'b0, addr[ADDR_W-1:PAGE_SHIFT], attr, 3'b111};
  endfunction

  always_comb begin
    steps = (steps_cfg_q > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS) : steps_cfg_q;
    for (int k = 0; k < NUM_SIZES; k++) begin
      size_ok[k] = ((start_q & ((ADDR_W'(1) << (PAGE_SHIFT + 1 + 2 * k)) - ADDR_W'(1)))
                    == '0) && (len_q >= (LEN_W'(1) << (PAGE_SHIFT + 1 + 2 * k)));
    end
    sel = '0;
    for (int k = 0; k < NUM_SIZES; k++) begin
      if (size_ok[k] && (SEL_W'(k) <= steps)) begin
        sel = SEL_W'(k);
      end
    end
    sz        = ADDR_W'(1) << (PAGE_SHIFT + 2 * sel);
    two_sz    = sz << 1;
    odd       = len_q >= two_sz;
    short_len = len_q < sz;
    advance   = odd ? two_sz : sz;
    len_next  = short_len ? '0 : len_q - advance;
    odd_addr  = start_q + sz;
    pages_m1  = PAGES_W'((sz >> PAGE_SHIFT) - ADDR_W'(1));
    len_zero  = len_q == '0;
    full      = ({1'b0, wired_q} >= entries_cfg_q) || (wired_q >= LIMIT);
  end

  assign status_o.res_last = len_zero || full || (len_next == '0);

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    wired_d = wired_q;
    if (cmd_i.load) begin
      start_d = start_address_i;
      len_d   = region_length_i;
    end else if (cmd_i.emit && !len_zero && !full) begin
      start_d = start_q + advance;
      len_d   = len_next;
      wired_d = wired_q + INDEX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wired_q       <= '0;
      steps_cfg_q   <= MAX_STEPS_RESET;
      entries_cfg_q <= TLB_ENTRIES_RESET;
    end else begin
      wired_q <= wired_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_PAGE_STEPS: steps_cfg_q   <= cfg_data_i[STEPS_W-1:0];
          CFG_TLB_ENTRIES:    entries_cfg_q <= cfg_data_i[ENTRIES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    if (cmd_i.load) begin
      attr_q <= cache_attr_i;
    end
    if (cmd_i.emit) begin
      if (len_zero || full) begin
        idx_q     <= '0;
        mask_q    <= '0;
        hi_q      <= '0;
        lo_even_q <= '0;
        lo_odd_q  <= '0;
        stat_q    <= len_zero ? STAT_EMPTY : STAT_FULL;
        last_q    <= 1'b1;
      end else begin
        idx_q     <= wired_q;
        mask_q    <= {pages_m1, 13'b0};
        hi_q      <= start_q;
        lo_even_q <= lo_word(start_q, attr_q);
        lo_odd_q  <= odd ? lo_word(odd_addr, attr_q) : '0;
        stat_q    <= STAT_ENTRY;
        last_q    <= len_next == '0;
      end
    end
  end

  assign tlb_index_o     = idx_q;
  assign page_mask_o     = mask_q;
  assign entry_hi_o      = hi_q;
  assign entry_lo_even_o = lo_even_q;
  assign entry_lo_odd_o  = lo_odd_q;
  assign entry_status_o  = stat_q;
  assign last_o          = last_q;

endmodule

[sv/tlbimg_ctrl.sv]
// controller: request handshakes and walk sequencing
`timescale 1ns / 1ps

module tlbimg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tlbimg_pkg::dp_cmd_t    cmd_o,
  input  tlbimg_pkg::dp_status_t status_i
);
  import tlbimg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTRL_IDLE: begin
        if (in_valid_i) begin
          state_d = CTRL_GEN;
        end
      end
      CTRL_GEN: begin
        if (slot_free && status_i.res_last) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CTRL_GEN: begin
        cmd_o.emit = slot_free;
        if (slot_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/tlb_identity_map_generator_unit.sv]
// Identity-map generator for wired MIPS TLB entries. A region request (start, length,
// cache attribute) is walked one TLB entry per clock while the result channel does not
// stall: each such cycle the datapath picks the largest page size allowed by alignment,
// remaining length and the max_page_steps register, and writes one result into the
// output register. The block takes the request first, then emits its results, and takes
// no new region until the last result of the current one is issued. Results are 1 to 64
// per region. The wired counter persists across regions; once it reaches tlb_entries or
// WIRED_LIMIT every later region of nonzero length returns one out-of-entries result
// until reset. Configuration writes belong in idle periods.
`timescale 1ns / 1ps

module tlb_identity_map_generator_unit #(
  parameter int unsigned WIRED_LIMIT = 63
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tlbimg_region_if.sink                     region_i,
  tlbimg_entry_if.source                    entry_o,
  input  logic                              cfg_we_i,
  input  logic [tlbimg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlbimg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tlbimg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  tlbimg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (region_i.valid),
    .in_ready_o  (region_i.ready),
    .out_valid_o (entry_o.valid),
    .out_ready_i (entry_o.ready),
    .cmd_o       (cmd),
    .status_i    (dp_status)
  );

  tlbimg_datapath #(
    .WIRED_LIMIT (WIRED_LIMIT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .start_address_i (region_i.start_address),
    .region_length_i (region_i.region_length),
    .cache_attr_i    (region_i.cache_attr),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .tlb_index_o     (entry_o.tlb_index),
    .page_mask_o     (entry_o.page_mask),
    .entry_hi_o      (entry_o.entry_hi),
    .entry_lo_even_o (entry_o.entry_lo_even),
    .entry_lo_odd_o  (entry_o.entry_lo_odd),
    .entry_status_o  (entry_o.status),
    .last_o          (entry_o.last)
  );

endmodule

[sv/tlbimg_checker.sv]
// port-level checks for the tlb identity map generator
`timescale 1ns / 1ps

module tlbimg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [tlbimg_pkg::INDEX_W-1:0]    tlb_index_i,
  input logic [tlbimg_pkg::STATUS_W-1:0]   status_i,
  input logic                              last_i
);
  import tlbimg_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STAT_ENTRY |-> last_i && tlb_index_i == '0)
    else $error("error result not final or carries an index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new request taken while a region is being walked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_ENTRY |-> tlb_index_i != 6'd63)
    else $error("wired index beyond the wired limit");

endmodule

bind tlb_identity_map_generator_unit tlbimg_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (region_i.valid),
  .in_ready_i  (region_i.ready),
  .out_valid_i (entry_o.valid),
  .out_ready_i (entry_o.ready),
  .tlb_index_i (entry_o.tlb_index),
  .status_i    (entry_o.status),
  .last_i      (entry_o.last)
);
